@@ hdl/lcg_pkg.sv @@
package lcg_pkg;

    localparam int SINE_ADDR_BITS_DEF = 10;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_STEP = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWEEP_STEP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENV_STEP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME     = 3'd4;

    localparam logic [23:0] ENV_ONE     = 24'h800000;
    localparam logic [63:0] HALF_PI_Q40 = 64'h0000_0192_1FB5_4443;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROM,
        S_MUL1,
        S_MUL2,
        S_EMIT
    } t_state;

    // round(32767*sin(pi/2 * k / 2^(addr_bits-2))), taylor series in q30
    function automatic logic [15:0] quarter_sine(input logic [31:0] k, input int addr_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x  = ({32'd0, k} * HALF_PI_Q40 + (64'd1 << (7 + addr_bits))) >> (8 + addr_bits);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd272;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd210;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        r  = (64'd32767 * s + (64'd1 << 29)) >> 30;
        return r[15:0];
    endfunction

endpackage

@@ hdl/linear_chirp_generator.sv @@
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_restart
// out       output     o_out_valid / i_out_ready  o_sample, o_active, o_final_sample
// cfg       input      i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// a sample of a running sweep goes through accept, sine rom read, two passes
// through the one 15x24 multiplier (volume, then envelope), and the emit step.
// an idle tick (no sweep running) goes through accept and emit only.
// o_in_ready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next transaction is taken while it is held.
// the emit step waits while the output register is full and not being drained.
// reset is synchronous and active low and leaves no sweep running.
module linear_chirp_generator
    import lcg_pkg::*;
#(
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_restart,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [15:0]     o_sample,
    output logic                   o_active,
    output logic                   o_final_sample,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SineSize    = 1 << SINE_ADDR_BITS;
    localparam int SineQuarter = 1 << (SINE_ADDR_BITS - 2);

    typedef logic signed [15:0] t_rom [SineSize];

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [31:0] quad;
        logic [31:0] r;
        logic [15:0] v;
        for (int j = 0; j < SineSize; j++) begin
            quad = 32'(j) >> (SINE_ADDR_BITS - 2);
            r    = 32'(j) & 32'(SineQuarter - 1);
            v    = quad[0] ? quarter_sine(32'(SineQuarter) - r, SINE_ADDR_BITS)
                           : quarter_sine(r, SINE_ADDR_BITS);
            rom[j] = quad[1] ? -v : v;
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // configuration
    logic [31:0] r_start_step;
    logic [31:0] r_sweep_step;
    logic [15:0] r_length;
    logic [23:0] r_env_step;
    logic [14:0] r_volume;

    // sweep state
    t_state      r_state, n_state;
    logic [31:0] r_phase_acc;
    logic [31:0] r_phase_step;
    logic [23:0] r_envelope;
    logic [15:0] r_sample_index;
    logic        r_running;

    // datapath
    logic signed [15:0] r_rom_q;
    logic [14:0]        r_mag;
    logic               r_neg;

    logic               r_out_valid;
    logic signed [15:0] r_sample;
    logic               r_active;
    logic               r_final;

    logic        in_fire;
    logic        emit;
    logic        last;
    logic [14:0] mul_a;
    logic [23:0] mul_b;
    logic [38:0] mul_p;
    logic [15:0] rom_abs;
    logic [SINE_ADDR_BITS-1:0] rom_addr;

    assign o_in_ready     = (r_state == S_IDLE);
    assign in_fire        = i_in_valid && o_in_ready;
    assign emit           = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign last           = ({1'b0, r_sample_index} + 17'd1) >= {1'b0, r_length};
    assign rom_addr       = r_phase_acc[31 -: SINE_ADDR_BITS];
    assign rom_abs        = r_rom_q[15] ? -r_rom_q : r_rom_q;

    // shared multiplier: volume pass, then envelope pass
    assign mul_a = (r_state == S_MUL1) ? rom_abs[14:0] : r_mag;
    assign mul_b = (r_state == S_MUL1) ? {9'd0, r_volume} : r_envelope;
    assign mul_p = {24'd0, mul_a} * {15'd0, mul_b};

    always_ff @(posedge i_clk) begin
        r_rom_q <= SINE_ROM[rom_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_restart ? (r_length != 16'd0) : r_running) begin
                        n_state = S_ROM;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_ROM:  n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_EMIT;
            S_EMIT: begin
                if (emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_step <= '0;
            r_sweep_step <= '0;
            r_length     <= '0;
            r_env_step   <= '0;
            r_volume     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_STEP: r_start_step <= i_cfg_data;
                CFG_SWEEP_STEP: r_sweep_step <= i_cfg_data;
                CFG_LENGTH:     r_length     <= i_cfg_data[15:0];
                CFG_ENV_STEP:   r_env_step   <= i_cfg_data[23:0];
                CFG_VOLUME:     r_volume     <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc    <= '0;
            r_phase_step   <= '0;
            r_envelope     <= '0;
            r_sample_index <= '0;
            r_running      <= 1'b0;
        end else if (in_fire && i_restart) begin
            r_phase_acc    <= '0;
            r_phase_step   <= r_start_step;
            r_envelope     <= ENV_ONE;
            r_sample_index <= '0;
            r_running      <= (r_length != 16'd0);
        end else if (emit && r_running) begin
            r_phase_acc    <= r_phase_acc + r_phase_step;
            r_phase_step   <= r_phase_step + r_sweep_step;
            r_envelope     <= (r_envelope > r_env_step) ? (r_envelope - r_env_step) : 24'd0;
            r_sample_index <= r_sample_index + 16'd1;
            if (last) begin
                r_running <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL1: begin
                r_mag <= mul_p[29:15];
                r_neg <= r_rom_q[15];
            end
            S_MUL2: r_mag <= mul_p[37:23];
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_running) begin
                r_sample <= r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
                r_active <= 1'b1;
                r_final  <= last;
            end else begin
                r_sample <= '0;
                r_active <= 1'b0;
                r_final  <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_sample;
    assign o_active       = r_active;
    assign o_final_sample = r_final;

endmodule

@@ hdl/lcg_checker.sv @@
module lcg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_sample,
    input logic               o_active,
    input logic               o_final_sample
);

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample)
            && $stable(o_active) && $stable(o_final_sample))
        else $error("output changed while stalled");

    // one transaction at a time through the sequencer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an accepted transaction");

    // an idle tick is all zero
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_active |-> o_sample == 16'sd0 && !o_final_sample)
        else $error("inactive sample not zero");

    // the rom never reaches full negative scale
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sample != 16'sh8000)
        else $error("sample out of range");

endmodule

bind linear_chirp_generator lcg_checker u_lcg_checker (.*);
